@@ design/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared widths, constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned IdxW        = 8;
  localparam int unsigned PermDepth   = 256;
  localparam int unsigned CountW      = 9;
  localparam int unsigned KeyMaxBytes = 256;

  localparam logic CmdKey  = 1'b0;
  localparam logic CmdData = 1'b1;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    logic key_wr;
    logic sched_start;
    logic init_step;
    logic ks_read;
    logic ks_mix;
    logic ks_write_n;
    logic ks_write_j;
    logic sched_done;
    logic gen_start;
    logic gen_read_j;
    logic gen_write_i;
    logic gen_write_j;
    logic pass_start;
    logic out_load_now;
    logic out_load_held;
  } rc4_cmd_t;

  typedef struct packed {
    logic keyed;
    logic step_last;
    logic out_free;
  } rc4_status_t;

endpackage

@@ design/rc4_if.sv @@
// ----------------------------------------------------------------------------
// rc4_if
// Valid/ready channels for cipher input beats and result beats.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  rc4_pkg::byte_t       in_byte;
  logic                 key_last;

  modport source (output valid, output cmd, output in_byte, output key_last, input ready);
  modport sink   (input valid, input cmd, input in_byte, input key_last, output ready);
endinterface

interface rc4_out_if;
  logic                 valid;
  logic                 ready;
  rc4_pkg::byte_t       out_byte;
  logic                 not_keyed;

  modport source (output valid, output out_byte, output not_keyed, input ready);
  modport sink   (input valid, input out_byte, input not_keyed, output ready);
endinterface

@@ design/rc4_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// Last key byte: 256-entry fill, then read, mix, write n, write j for each
// entry. Keyed data byte: reads at i, j and the output index plus the
// swap write-back on the one read and one write port of the permutation
// memory. Reset clears indices, key count and keyed flag.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX_BYTES = rc4_pkg::KeyMaxBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  rc4_pkg::rc4_cmd_t    cmd;
  rc4_pkg::rc4_status_t status;

  rc4_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_cmd_i      (in_i.cmd),
    .in_key_last_i (in_i.key_last),
    .in_ready_o    (in_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  rc4_dp #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_byte_i       (in_i.in_byte),
    .status_o        (status),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .out_not_keyed_o (out_o.not_keyed)
  );

endmodule

@@ design/rc4_ctrl.sv @@
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key loading, key schedule, keystream steps and result hand-off.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  input  logic                 in_key_last_i,
  output logic                 in_ready_o,
  input  rc4_pkg::rc4_status_t status_i,
  output rc4_pkg::rc4_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_INIT = 10'b0000000010,
    S_KRD  = 10'b0000000100,
    S_KJ   = 10'b0000001000,
    S_KWN  = 10'b0000010000,
    S_KWJ  = 10'b0000100000,
    S_GJ   = 10'b0001000000,
    S_GR   = 10'b0010000000,
    S_GW   = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == rc4_pkg::CmdKey) begin
            cmd_o.key_wr = 1'b1;
            if (in_key_last_i) begin
              cmd_o.sched_start = 1'b1;
              state_d           = S_INIT;
            end
          end else if (status_i.keyed) begin
            cmd_o.gen_start = 1'b1;
            state_d         = S_GJ;
          end else begin
            cmd_o.pass_start = 1'b1;
            if (status_i.out_free) begin
              cmd_o.out_load_now = 1'b1;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_KRD;
        end
      end
      S_KRD: begin
        cmd_o.ks_read = 1'b1;
        state_d       = S_KJ;
      end
      S_KJ: begin
        cmd_o.ks_mix = 1'b1;
        state_d      = S_KWN;
      end
      S_KWN: begin
        cmd_o.ks_write_n = 1'b1;
        state_d          = S_KWJ;
      end
      S_KWJ: begin
        cmd_o.ks_write_j = 1'b1;
        if (status_i.step_last) begin
          cmd_o.sched_done = 1'b1;
          state_d          = S_IDLE;
        end else begin
          state_d = S_KRD;
        end
      end
      S_GJ: begin
        cmd_o.gen_read_j = 1'b1;
        state_d          = S_GR;
      end
      S_GR: begin
        cmd_o.gen_write_i = 1'b1;
        state_d           = S_GW;
      end
      S_GW: begin
        cmd_o.gen_write_j = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load_now = 1'b1;
          state_d            = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load_held = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/rc4_dp.sv @@
// ----------------------------------------------------------------------------
// rc4_dp
// Permutation and key memories, schedule and generator indices, result register.
// ----------------------------------------------------------------------------
module rc4_dp #(
  parameter int unsigned KEY_MAX_BYTES = rc4_pkg::KeyMaxBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rc4_pkg::rc4_cmd_t    cmd_i,
  input  rc4_pkg::byte_t       in_byte_i,
  output rc4_pkg::rc4_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rc4_pkg::byte_t       out_byte_o,
  output logic                 out_not_keyed_o
);

  localparam int unsigned KeyAw  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int unsigned CountW = rc4_pkg::CountW;

  rc4_pkg::byte_t perm_mem [rc4_pkg::PermDepth];
  rc4_pkg::byte_t key_mem  [KEY_MAX_BYTES];

  rc4_pkg::byte_t perm_rdata_q, key_rdata_q;
  rc4_pkg::idx_t  perm_raddr, perm_waddr;
  rc4_pkg::byte_t perm_wdata;
  logic           perm_re, perm_we, key_we;

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [CountW-1:0] len_q, len_d, pos_q, pos_d, pos_inc;
  rc4_pkg::idx_t     n_q, n_d, kj_q, kj_d, i_q, i_d, j_q, j_d;
  logic              keyed_q, keyed_d, out_valid_q, out_valid_d;

  rc4_pkg::byte_t s_a_q, s_b_q, r_q, byte_q, res_q, out_byte_q;
  logic           res_nk_q, out_nk_q;
  rc4_pkg::byte_t mix_j, ks, gen_out, res_nxt;
  logic           res_nk_nxt;

  assign key_we    = cmd_i.key_wr && (count_q < CountW'(KEY_MAX_BYTES));
  assign count_inc = count_q + CountW'(key_we);
  assign pos_inc   = pos_q + CountW'(1);
  assign mix_j     = kj_q + perm_rdata_q + key_rdata_q;

  always_comb begin
    perm_raddr = n_q;
    if (cmd_i.ks_mix) begin
      perm_raddr = mix_j;
    end else if (cmd_i.gen_start) begin
      perm_raddr = i_q + rc4_pkg::IdxW'(1);
    end else if (cmd_i.gen_read_j) begin
      perm_raddr = j_q + perm_rdata_q;
    end else if (cmd_i.gen_write_i) begin
      perm_raddr = s_a_q + perm_rdata_q;
    end
  end

  assign perm_re = cmd_i.ks_read || cmd_i.ks_mix || cmd_i.gen_start ||
                   cmd_i.gen_read_j || cmd_i.gen_write_i;
  assign perm_we = cmd_i.init_step || cmd_i.ks_write_n || cmd_i.ks_write_j ||
                   cmd_i.gen_write_i || cmd_i.gen_write_j;

  always_comb begin
    perm_waddr = n_q;
    perm_wdata = n_q;
    if (cmd_i.ks_write_n) begin
      perm_wdata = perm_rdata_q;
    end else if (cmd_i.ks_write_j) begin
      perm_waddr = kj_q;
      perm_wdata = s_a_q;
    end else if (cmd_i.gen_write_i) begin
      perm_waddr = i_q;
      perm_wdata = perm_rdata_q;
    end else if (cmd_i.gen_write_j) begin
      perm_waddr = j_q;
      perm_wdata = s_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rdata_q <= perm_mem[perm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[count_q[KeyAw-1:0]] <= in_byte_i;
    end
    if (cmd_i.ks_read) begin
      key_rdata_q <= key_mem[pos_q[KeyAw-1:0]];
    end
  end

  // forward the swapped entries when the output index hits i or j
  always_comb begin
    if (r_q == j_q) begin
      ks = s_a_q;
    end else if (r_q == i_q) begin
      ks = s_b_q;
    end else begin
      ks = perm_rdata_q;
    end
  end

  assign gen_out    = byte_q ^ ks;
  assign res_nxt    = cmd_i.gen_write_j ? gen_out : in_byte_i;
  assign res_nk_nxt = !cmd_i.gen_write_j;

  always_comb begin
    count_d     = count_inc;
    len_d       = len_q;
    n_d         = n_q;
    kj_d        = kj_q;
    pos_d       = pos_q;
    i_d         = i_q;
    j_d         = j_q;
    keyed_d     = keyed_q;
    out_valid_d = out_valid_q;
    if (cmd_i.sched_start) begin
      count_d = '0;
      len_d   = count_inc;
      n_d     = '0;
      kj_d    = '0;
      pos_d   = '0;
    end
    if (cmd_i.init_step || cmd_i.ks_write_j) begin
      n_d = n_q + rc4_pkg::IdxW'(1);
    end
    if (cmd_i.ks_mix) begin
      kj_d = mix_j;
    end
    if (cmd_i.ks_write_j) begin
      pos_d = (pos_inc == len_q) ? '0 : pos_inc;
    end
    if (cmd_i.sched_done) begin
      i_d     = '0;
      j_d     = '0;
      keyed_d = 1'b1;
    end
    if (cmd_i.gen_start) begin
      i_d = i_q + rc4_pkg::IdxW'(1);
    end
    if (cmd_i.gen_read_j) begin
      j_d = j_q + perm_rdata_q;
    end
    if (cmd_i.out_load_now || cmd_i.out_load_held) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      len_q       <= '0;
      n_q         <= '0;
      kj_q        <= '0;
      pos_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      len_q       <= len_d;
      n_q         <= n_d;
      kj_q        <= kj_d;
      pos_q       <= pos_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_mix || cmd_i.gen_read_j) begin
      s_a_q <= perm_rdata_q;
    end
    if (cmd_i.gen_write_i) begin
      s_b_q <= perm_rdata_q;
      r_q   <= s_a_q + perm_rdata_q;
    end
    if (cmd_i.gen_start) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.gen_write_j || cmd_i.pass_start) begin
      res_q    <= res_nxt;
      res_nk_q <= res_nk_nxt;
    end
    if (cmd_i.out_load_now) begin
      out_byte_q <= res_nxt;
      out_nk_q   <= res_nk_nxt;
    end else if (cmd_i.out_load_held) begin
      out_byte_q <= res_q;
      out_nk_q   <= res_nk_q;
    end
  end

  assign status_o.keyed     = keyed_q;
  assign status_o.step_last = (n_q == '1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_not_keyed_o = out_nk_q;

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_we |-> $onehot({cmd_i.init_step, cmd_i.ks_write_n, cmd_i.ks_write_j,
                         cmd_i.gen_write_i, cmd_i.gen_write_j}))
    else $error("rc4_dp: more than one permutation write in a cycle");
  a_gen_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gen_write_j |=> out_valid_q)
    else $error("rc4_dp: keystream result not presented");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(KEY_MAX_BYTES))
    else $error("rc4_dp: key count beyond limit");
  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_q |=> keyed_q)
    else $error("rc4_dp: keyed flag dropped");
  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sched_done |-> (n_q == '1) && cmd_i.ks_write_j)
    else $error("rc4_dp: schedule ended early");
`endif

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the RC4 byte cipher against a keystream model kept beside it. It
// covers data bytes before any key, short, full-length and overlong keys, and
// data mixed into a key load, followed by random key and data streams.
// The sender works in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned BeatTarget = 600;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 1500;
  localparam int unsigned LongHold   = 300;

  typedef struct packed {
    rc4_pkg::byte_t out_byte;
    logic           not_keyed;
  } cipher_beat_t;

  class keystream_tracker;
    rc4_pkg::byte_t perm [rc4_pkg::PermDepth];
    rc4_pkg::byte_t keys [rc4_pkg::PermDepth];
    int unsigned    key_count;
    rc4_pkg::idx_t  i_idx;
    rc4_pkg::idx_t  j_idx;
    bit             keyed;
    cipher_beat_t   expected_beats [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    schedules;

    function new();
      key_count = 0;
      i_idx     = '0;
      j_idx     = '0;
      keyed     = 1'b0;
      errors    = 0;
      checked   = 0;
      schedules = 0;
    endfunction

    function void schedule_key(int unsigned len);
      rc4_pkg::idx_t  mix;
      int unsigned    pos;
      rc4_pkg::byte_t t;
      mix = '0;
      pos = 0;
      for (int n = 0; n < rc4_pkg::PermDepth; n++) perm[n] = rc4_pkg::byte_t'(n);
      for (int n = 0; n < rc4_pkg::PermDepth; n++) begin
        mix = mix + perm[n] + keys[pos];
        t = perm[n];
        perm[n] = perm[mix];
        perm[mix] = t;
        pos++;
        if (pos >= len) pos = 0;
      end
    endfunction

    function rc4_pkg::byte_t keystream_xor(rc4_pkg::byte_t data);
      rc4_pkg::byte_t t;
      rc4_pkg::idx_t  r;
      i_idx = i_idx + 8'd1;
      j_idx = j_idx + perm[i_idx];
      t = perm[i_idx];
      perm[i_idx] = perm[j_idx];
      perm[j_idx] = t;
      r = perm[i_idx] + perm[j_idx];
      return data ^ perm[r];
    endfunction

    function void note_beat(logic cmd, rc4_pkg::byte_t data, logic last);
      cipher_beat_t want;
      if (cmd == rc4_pkg::CmdKey) begin
        if (key_count < rc4_pkg::KeyMaxBytes) begin
          keys[key_count] = data;
          key_count++;
        end
        if (last) begin
          schedule_key(key_count == 0 ? 1 : key_count);
          key_count = 0;
          i_idx     = '0;
          j_idx     = '0;
          keyed     = 1'b1;
          schedules++;
        end
        return;
      end
      want.not_keyed = !keyed;
      if (keyed) want.out_byte = keystream_xor(data);
      else want.out_byte = data;
      expected_beats.insert(expected_beats.size(), want);
    endfunction

    function void check_beat(rc4_pkg::byte_t got_byte, logic got_not_keyed);
      cipher_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result: out_byte=%02h not_keyed=%0b", got_byte, got_not_keyed);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      checked++;
      if (got_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got_byte);
        errors++;
      end
      if (got_not_keyed !== want.not_keyed) begin
        $error("not_keyed: expected %0b, actual %0b", want.not_keyed, got_not_keyed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  keystream_tracker tracker = new();

  int unsigned beats_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned cycles        = 0;
  bit          steady        = 1'b0;
  bit          long_hold_req = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tracker.note_beat(in_if.cmd, in_if.in_byte, in_if.key_last);
      end
      if (out_if.valid && out_if.ready) tracker.check_beat(out_if.out_byte, out_if.not_keyed);
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned n;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 64);
        n = 0;
        while (n < span && !long_hold_req) begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            2: out_if.ready <= ($urandom_range(0, 1) != 0);
            default: out_if.ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk_i);
          n++;
        end
      end
    end
  end

  function automatic rc4_pkg::byte_t rand_byte();
    return rc4_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady) begin
      gap = $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input logic cmd, input rc4_pkg::byte_t data, input logic last);
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.in_byte  <= data;
    in_if.key_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
    pace();
  endtask

  task automatic send_data(input int unsigned count);
    for (int k = 0; k < count; k++) begin
      send_beat(rc4_pkg::CmdData, rand_byte(), $urandom_range(0, 1) != 0);
    end
  endtask

  task automatic load_key(input int unsigned len);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) send_data(1);
      send_beat(rc4_pkg::CmdKey, rand_byte(), k == len - 1);
    end
  endtask

  task automatic send_noise(input int unsigned count);
    for (int k = 0; k < count; k++) begin
      send_beat(($urandom_range(0, 1) != 0) ? rc4_pkg::CmdData : rc4_pkg::CmdKey, rand_byte(),
                $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin : sender
    int unsigned seq;
    int unsigned len;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= rc4_pkg::CmdKey;
    in_if.in_byte  <= '0;
    in_if.key_last <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(rc4_pkg::CmdData, 8'h00, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'hff, 1'b1);
    send_beat(rc4_pkg::CmdData, 8'h5a, 1'b0);
    send_beat(rc4_pkg::CmdKey, 8'h00, 1'b0);
    send_beat(rc4_pkg::CmdKey, 8'hff, 1'b0);
    send_beat(rc4_pkg::CmdKey, 8'h80, 1'b1);
    send_beat(rc4_pkg::CmdData, 8'h00, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'hff, 1'b1);
    send_beat(rc4_pkg::CmdData, 8'h55, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'haa, 1'b0);
    send_beat(rc4_pkg::CmdKey, 8'hff, 1'b1);
    send_beat(rc4_pkg::CmdData, 8'h00, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'hff, 1'b0);
    send_beat(rc4_pkg::CmdKey, 8'h01, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'h12, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'h34, 1'b1);
    send_beat(rc4_pkg::CmdKey, 8'h02, 1'b1);
    send_beat(rc4_pkg::CmdData, 8'h80, 1'b0);
    send_beat(rc4_pkg::CmdData, 8'h7f, 1'b0);

    seq = 0;
    while (beats_sent < BeatTarget) begin
      if (seq == 0) begin
        long_hold_req = 1'b1;
        steady = 1'b1;
        send_data(60);
        steady = 1'b0;
      end else if (seq > 3 && $urandom_range(0, 9) == 0) begin
        send_noise($urandom_range(1, 8));
      end else begin
        if (seq == 1) len = $urandom_range(257, 300);
        else if (seq == 2) len = rc4_pkg::KeyMaxBytes;
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(17, 256);
        else len = $urandom_range(1, 16);
        load_key(len);
        send_data($urandom_range(1, 40));
      end
      seq++;
    end
    in_if.valid <= 1'b0;

    while (tracker.expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("tb: %0d beats sent, %0d results checked, %0d key schedules run",
             beats_sent, tracker.checked, tracker.schedules);
    $display("tb: keys of 1 to over 256 bytes, unkeyed data, data within key loads");
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
